// ===== sv/q4bq_pkg.sv =====
// Shared types, constants and code arithmetic for the 4-bit block quantizer.
// No dependencies; imported by q4bq_coder, q4_block_quantizer_unit and the testbench.
package q4bq_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned BLOCK_SIZE  = 32;
  localparam int unsigned FILL_W      = $clog2(BLOCK_SIZE);
  localparam int unsigned PAIR_COUNT  = BLOCK_SIZE / 2;
  localparam int unsigned PAIR_AW     = $clog2(PAIR_COUNT);
  localparam int unsigned MAG_W       = SAMPLE_W + 1;
  localparam int unsigned THR_W       = MAG_W + 4;
  localparam int unsigned NUM_THR     = 8;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned SCALE_W     = 21;
  localparam int unsigned SCALE_FRAC  = 9;
  localparam int unsigned SCALE_NUM_W = MAG_W + SCALE_FRAC;
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned PROD_W      = SCALE_NUM_W + RECIP_W;

  // ceil(2^29 / 15): exact floor division by 15 for numerators below 2^25
  localparam logic [RECIP_W-1:0]     RECIP      = RECIP_W'(35791395);
  localparam logic [SCALE_NUM_W-1:0] ROUND_BIAS = SCALE_NUM_W'(7);

  localparam logic [CODE_W-1:0] CODE_ZERO = CODE_W'(8);
  localparam logic [CODE_W-1:0] CODE_MAX  = CODE_W'(15);
  localparam logic [CODE_W-1:0] STEP_MAX  = CODE_W'(NUM_THR);

  typedef logic signed [SAMPLE_W-1:0]     sample_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [NUM_THR-1:0][THR_W-1:0]  thr_t;
  typedef logic [CODE_W-1:0]              code_t;

  typedef struct packed {
    logic valid;
    logic last;
  } emit_ctl_t;

  function automatic mag_t mag_of(sample_t x);
    mag_t sx;
    sx = {x[SAMPLE_W-1], x};
    return x[SAMPLE_W-1] ? (mag_t'(0) - sx) : sx;
  endfunction

  // Rounded step count r = round(15|x| / 2m) equals the number of odd
  // multiples (2k+1)*m that 15|x| reaches, k = 0..7.
  function automatic code_t code_of(sample_t x, thr_t thr, logic zero_max);
    mag_t             mag;
    logic [THR_W-1:0] p15;
    code_t            r;
    mag = mag_of(x);
    p15 = (THR_W'(mag) << 4) - THR_W'(mag);
    r   = '0;
    for (int k = 0; k < NUM_THR; k++) begin
      r = r + code_t'(p15 >= thr[k]);
    end
    if (zero_max) begin
      return CODE_ZERO;
    end else if (x[SAMPLE_W-1]) begin
      return CODE_ZERO - r;
    end else if (r == STEP_MAX) begin
      return CODE_MAX;
    end else begin
      return CODE_ZERO + r;
    end
  endfunction

endpackage

// ===== sv/q4bq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module q4bq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/q4bq_coder.sv =====
// Code stage: turns a pair of buffered samples into a packed code byte and
// registers the result word. Depends on q4bq_pkg.
module q4bq_coder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  q4bq_pkg::emit_ctl_t          ctl_i,
  input  q4bq_pkg::sample_t            even_i,
  input  q4bq_pkg::sample_t            odd_i,
  input  q4bq_pkg::thr_t               thr_i,
  input  logic                         zero_max_i,
  output logic                         strobe_o,
  output logic [2*q4bq_pkg::CODE_W-1:0] packed_o,
  output logic                         last_o
);
  import q4bq_pkg::*;

  logic                  strobe_q;
  logic                  last_q;
  logic [2*CODE_W-1:0]   packed_q;
  logic [2*CODE_W-1:0]   packed_d;

  assign packed_d = {code_of(odd_i, thr_i, zero_max_i), code_of(even_i, thr_i, zero_max_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= ctl_i.valid;
      last_q   <= ctl_i.valid && ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      packed_q <= packed_d;
    end
  end

  assign strobe_o = strobe_q;
  assign packed_o = packed_q;
  assign last_o   = last_q;

endmodule

// ===== sv/q4bq_unit_top.sv =====
// Holds no logic: the top level of the block is in q4_block_quantizer_unit.sv.
// No dependencies.

// ===== sv/q4_block_quantizer_unit.sv =====
// Top level of the 4-bit block quantizer: fill sequencer, max tracking,
// scale and threshold setup, even/odd sample RAMs. Depends on q4bq_pkg,
// q4bq_ram and q4bq_coder.
//
//  channel   ports                                        handshake
//  input     sample_i                                     start & !busy
//  result    packed_codes_o, block_scale_o, last_of_block_o  strobe_o, one cycle
//
// One sample is taken per cycle while the block is filling (busy low).
// After the 32nd sample busy stays high through the scale state, which forms the
// scale and the code thresholds, and the 16 reads of the even/odd RAM pair.
// Results pass the RAM read and coder output registers, one per cycle, 16 per block.
// Reset clears the fill count, running maximum and sequencer; RAM contents
// are not cleared. The receiver cannot stall the result words.
module q4_block_quantizer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [q4bq_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               strobe_o,
  output logic [2*q4bq_pkg::CODE_W-1:0]      packed_codes_o,
  output logic [q4bq_pkg::SCALE_W-1:0]       block_scale_o,
  output logic                               last_of_block_o
);
  import q4bq_pkg::*;

  typedef enum logic [2:0] {
    ST_FILL  = 3'b001,
    ST_SCALE = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  mag_t                run_max_q, run_max_d;
  mag_t                emit_max_q;
  logic [PAIR_AW-1:0]  emit_q, emit_d;
  emit_ctl_t           rd_ctl_q, rd_ctl_d;
  thr_t                thr_q, thr_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;

  logic                accept;
  logic                final_smp;
  mag_t                mag_in;
  mag_t                new_max;
  logic                rd_en;
  logic                emit_end;
  logic [SCALE_NUM_W-1:0] scale_num;
  logic [PROD_W-1:0]   scale_prod;
  sample_t             even_rd, odd_rd;

  assign accept    = start && !busy;
  assign final_smp = (fill_q == FILL_W'(BLOCK_SIZE - 1));
  assign mag_in    = mag_of(sample_i);
  assign new_max   = (mag_in > run_max_q) ? mag_in : run_max_q;
  assign rd_en     = (state_q == ST_EMIT);
  assign emit_end  = (emit_q == PAIR_AW'(PAIR_COUNT - 1));
  assign busy      = (state_q != ST_FILL);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    run_max_d = run_max_q;
    emit_d    = emit_q;
    unique case (state_q)
      ST_FILL: begin
        if (accept) begin
          fill_d    = fill_q + FILL_W'(1);
          run_max_d = new_max;
          if (final_smp) begin
            fill_d    = '0;
            run_max_d = '0;
            state_d   = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        emit_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        emit_d = emit_q + PAIR_AW'(1);
        if (emit_end) begin
          state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  assign rd_ctl_d.valid = rd_en;
  assign rd_ctl_d.last  = rd_en && emit_end;

  // Scale = floor((m*512 + 7) / 15) via reciprocal multiply.
  assign scale_num  = {emit_max_q, SCALE_FRAC'(0)} + ROUND_BIAS;
  assign scale_prod = PROD_W'(scale_num) * PROD_W'(RECIP);
  assign scale_d    = scale_prod[RECIP_SHIFT +: SCALE_W];

  // Odd multiples of the block maximum: decision levels of the rounded code.
  always_comb begin
    for (int k = 0; k < NUM_THR; k++) begin
      thr_d[k] = THR_W'(emit_max_q) * THR_W'(2 * k + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      fill_q    <= '0;
      run_max_q <= '0;
      emit_q    <= '0;
      rd_ctl_q  <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      run_max_q <= run_max_d;
      emit_q    <= emit_d;
      rd_ctl_q  <= rd_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && final_smp) begin
      emit_max_q <= new_max;
    end
    if (state_q == ST_SCALE) begin
      scale_q <= scale_d;
      thr_q   <= thr_d;
    end
  end

  // Even samples go to one bank, odd to the other: one read yields a pair.
  q4bq_ram #(
    .DEPTH (PAIR_COUNT),
    .WIDTH (SAMPLE_W)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (accept && !fill_q[0]),
    .waddr_i (fill_q[FILL_W-1:1]),
    .wdata_i (sample_i),
    .re_i    (rd_en),
    .raddr_i (emit_q),
    .rdata_o (even_rd)
  );

  q4bq_ram #(
    .DEPTH (PAIR_COUNT),
    .WIDTH (SAMPLE_W)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (accept && fill_q[0]),
    .waddr_i (fill_q[FILL_W-1:1]),
    .wdata_i (sample_i),
    .re_i    (rd_en),
    .raddr_i (emit_q),
    .rdata_o (odd_rd)
  );

  q4bq_coder u_coder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rd_ctl_q),
    .even_i     (even_rd),
    .odd_i      (odd_rd),
    .thr_i      (thr_q),
    .zero_max_i (emit_max_q == '0),
    .strobe_o   (strobe_o),
    .packed_o   (packed_codes_o),
    .last_o     (last_of_block_o)
  );

  assign block_scale_o = scale_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_final_to_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_smp) |=> (state_q == ST_SCALE))
    else $error("full block did not start scale setup");

  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (fill_q == '0 && run_max_q == '0))
    else $error("fill state not cleared during emission");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_of_block_o) |=> !strobe_o)
    else $error("word after last of block");

endmodule

// ===== sim/tb_q4_block_quantizer_unit.sv =====
// Self-checking testbench for q4_block_quantizer_unit: streams signed samples,
// predicts the packed 4-bit codes and block scale of every block, checks each word.
// Depends on q4bq_pkg and the q4_block_quantizer_unit RTL.
module tb_q4_block_quantizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import q4bq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 17;
  localparam int          SAMPLE_MIN  = -(2 ** (int'(SAMPLE_W) - 1));
  localparam int          SAMPLE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
  localparam int          TIE_UNIT_MAX = SAMPLE_MAX / int'(CODE_MAX);

  typedef struct {
    sample_t value;
    bit      drain_first;
  } sample_word_t;

  typedef struct {
    logic [2*CODE_W-1:0]  codes;
    logic [SCALE_W-1:0]   scale;
    logic                 last;
  } quant_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  sample_t               sample_i = '0;
  logic                  strobe_o;
  logic [2*CODE_W-1:0]   packed_codes_o;
  logic [SCALE_W-1:0]    block_scale_o;
  logic                  last_of_block_o;

  sample_word_t   sample_queue[$];
  quant_word_t    expected_words[$];

  // predictor state for the block being filled
  sample_t        block_samples[BLOCK_SIZE];
  int unsigned    block_fill = 0;
  int unsigned    block_peak = 0;

  int unsigned    mismatch_count = 0;
  int unsigned    accepted_samples = 0;
  int unsigned    quiet_cycles = 0;

  q4_block_quantizer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_i        (sample_i),
    .strobe_o        (strobe_o),
    .packed_codes_o  (packed_codes_o),
    .block_scale_o   (block_scale_o),
    .last_of_block_o (last_of_block_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned magnitude_of(sample_t x);
    return (x < 0) ? int'(-int'(x)) : int'(x);
  endfunction

  // round half away from zero of 15|x| / 2*peak, offset to 8 and clamped
  function automatic logic [CODE_W-1:0] quant_code(sample_t x, int unsigned peak);
    longint unsigned num;
    longint unsigned den;
    longint unsigned steps;
    longint          level;
    if (peak == 0) begin
      return CODE_ZERO;
    end
    num   = longint'(CODE_MAX) * magnitude_of(x);
    den   = 2 * longint'(peak);
    steps = (2 * num + den) / (2 * den);
    level = (x < 0) ? longint'(CODE_ZERO) - longint'(steps)
                    : longint'(CODE_ZERO) + longint'(steps);
    if (level < 0) begin
      level = 0;
    end
    if (level > longint'(CODE_MAX)) begin
      level = longint'(CODE_MAX);
    end
    return CODE_W'(level);
  endfunction

  function automatic void absorb_sample(sample_t x);
    longint unsigned scale;
    quant_word_t     word;
    block_samples[block_fill] = x;
    if (magnitude_of(x) > block_peak) begin
      block_peak = magnitude_of(x);
    end
    block_fill++;
    if (block_fill == BLOCK_SIZE) begin
      scale = (longint'(block_peak) * (2 ** SCALE_FRAC) + 7) / longint'(CODE_MAX);
      for (int k = 0; k < PAIR_COUNT; k++) begin
        word.codes = {quant_code(block_samples[2*k+1], block_peak),
                      quant_code(block_samples[2*k], block_peak)};
        word.scale = SCALE_W'(scale);
        word.last  = (k == PAIR_COUNT - 1);
        expected_words.push_back(word);
      end
      block_fill = 0;
      block_peak = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 200) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  task automatic queue_sample(int value, bit drain_first = 1'b0);
    sample_word_t w;
    w.value       = sample_t'(value);
    w.drain_first = drain_first;
    sample_queue.push_back(w);
  endtask

  function automatic int amp_sample(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // one block of random content; the style picks the magnitude profile
  task automatic queue_random_block(bit drain_first);
    int style;
    int amp;
    int tie_unit;
    int spot;
    int value;
    style    = $urandom_range(0, 5);
    amp      = (style == 1) ? $urandom_range(1, 40) : $urandom_range(100, SAMPLE_MAX);
    tie_unit = $urandom_range(1, TIE_UNIT_MAX);
    spot     = $urandom_range(0, BLOCK_SIZE - 1);
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      case (style)
        0: value = int'(sample_t'($urandom));
        1, 2: value = amp_sample(amp);
        3: begin
          // hit exact half steps of 15x / 2*peak with peak = 15*tie_unit
          if (j == spot) begin
            value = ($urandom_range(0, 1) ? -1 : 1) * int'(CODE_MAX) * tie_unit;
          end else if ($urandom_range(0, 1)) begin
            value = ($urandom_range(0, 1) ? -1 : 1) * (2 * $urandom_range(0, 7) + 1)
                    * tie_unit;
          end else begin
            value = amp_sample(int'(CODE_MAX) * tie_unit);
          end
        end
        4: value = (j == spot) ? SAMPLE_MIN : int'(sample_t'($urandom));
        default: value = ($urandom_range(0, 3) == 0) ? amp_sample(3) : 0;
      endcase
      queue_sample(value, drain_first && (j == 0));
    end
  endtask

  function automatic bit take_gap();
    // no gaps through a long middle stretch
    if (accepted_samples >= 180 && accepted_samples < 300) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // driver: one word is held on the ports until start & !busy takes it
  always @(posedge clk_i) begin
    bit taken;
    taken = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        absorb_sample(sample_queue[0].value);
        void'(sample_queue.pop_front());
        accepted_samples++;
        taken = 1'b1;
      end
      if (!start || taken) begin
        if (sample_queue.size() == 0) begin
          start <= 1'b0;
        end else if (sample_queue[0].drain_first && expected_words.size() != 0) begin
          start <= 1'b0;
        end else if (take_gap()) begin
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          sample_i <= sample_queue[0].value;
        end
      end
    end
  end

  // monitor: every strobe carries one word, compared with the oldest prediction
  always @(posedge clk_i) begin
    quant_word_t want;
    if (rst_ni && strobe_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word codes=%02h scale=%0d last=%b",
                                  packed_codes_o, block_scale_o, last_of_block_o));
      end else begin
        want = expected_words.pop_front();
        if (packed_codes_o !== want.codes) begin
          report_mismatch($sformatf("packed_codes got %02h want %02h",
                                    packed_codes_o, want.codes));
        end
        if (block_scale_o !== want.scale) begin
          report_mismatch($sformatf("block_scale got %0d want %0d",
                                    block_scale_o, want.scale));
        end
        if (last_of_block_o !== want.last) begin
          report_mismatch($sformatf("last_of_block got %b want %b",
                                    last_of_block_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int tail;
    // all-zero block
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      queue_sample(0);
    end
    // full-scale extremes, peak is the most negative sample
    queue_sample(SAMPLE_MIN, 1'b1);
    queue_sample(SAMPLE_MAX);
    queue_sample(0);
    queue_sample(1);
    queue_sample(-1);
    queue_sample(-SAMPLE_MAX);
    queue_sample(16384);
    queue_sample(-16384);
    for (int j = 8; j < BLOCK_SIZE; j++) begin
      queue_sample(int'(sample_t'($urandom)));
    end
    // exact half steps at peak 15*2184; the peak itself rounds to 16 and clamps
    for (int k = 0; k < 8; k++) begin
      queue_sample((2 * k + 1) * TIE_UNIT_MAX);
      queue_sample(-(2 * k + 1) * TIE_UNIT_MAX);
    end
    for (int j = 16; j < BLOCK_SIZE; j++) begin
      queue_sample(amp_sample(int'(CODE_MAX) * TIE_UNIT_MAX - 1));
    end
    for (int b = 0; b < 11; b++) begin
      queue_random_block(b == 6);
    end
    // partial block: words that produce no result
    tail = $urandom_range(1, BLOCK_SIZE - 1);
    for (int j = 0; j < tail; j++) begin
      queue_sample(int'(sample_t'($urandom)));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_queue.size() != 0 || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/q4bq_pkg.sv
sv/q4bq_ram.sv
sv/q4bq_coder.sv
sv/q4bq_unit_top.sv
sv/q4_block_quantizer_unit.sv
sim/tb_q4_block_quantizer_unit.sv
